// File: src/atbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atbr_pkg: shared types and constants for branch resolution
// Branch kind codes, exception codes, Thumb condition codes and the
// registered item and result structures.
// ----------------------------------------------------------------------------
package atbr_pkg;

  typedef enum logic [2:0] {
    KIND_ARM_B       = 3'd0,
    KIND_ARM_BX      = 3'd1,
    KIND_ARM_BLX_IMM = 3'd2,
    KIND_THUMB_BCOND = 3'd3,
    KIND_THUMB_B     = 3'd4,
    KIND_THUMB_BL_LO = 3'd5,
    KIND_THUMB_BL_HI = 3'd6,
    KIND_THUMB_BX    = 3'd7
  } atbr_kind_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDEF = 2'd1,
    FAULT_SVC   = 2'd2
  } atbr_fault_t;

  // Condition codes; AL and NV are special in the Thumb branch slot.
  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_CS = 4'd2;
  localparam logic [3:0] COND_CC = 4'd3;
  localparam logic [3:0] COND_MI = 4'd4;
  localparam logic [3:0] COND_PL = 4'd5;
  localparam logic [3:0] COND_VS = 4'd6;
  localparam logic [3:0] COND_VC = 4'd7;
  localparam logic [3:0] COND_HI = 4'd8;
  localparam logic [3:0] COND_LS = 4'd9;
  localparam logic [3:0] COND_GE = 4'd10;
  localparam logic [3:0] COND_LT = 4'd11;
  localparam logic [3:0] COND_GT = 4'd12;
  localparam logic [3:0] COND_LE = 4'd13;
  localparam logic [3:0] COND_AL = 4'd14;
  localparam logic [3:0] COND_NV = 4'd15;

  typedef struct packed {
    atbr_kind_t  req_type;
    logic [31:0] instr;
    logic [31:0] pc_read;
    logic [31:0] reg_operand;
    logic [31:0] link_in;
    logic [3:0]  nzcv;
  } atbr_item_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] target;
    logic        link_write;
    logic [31:0] link_data;
    atbr_fault_t fault;
  } atbr_res_t;

endpackage
`default_nettype wire

// File: src/atbr_cond.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atbr_cond: condition check
// Evaluates a four-bit condition code against the NZCV flags.
// ----------------------------------------------------------------------------
module atbr_cond
  import atbr_pkg::*;
(
  input  wire logic [3:0] cond,
  input  wire logic [3:0] nzcv,
  output logic            pass
);

  logic flag_n;
  logic flag_z;
  logic flag_c;
  logic flag_v;

  assign flag_n = nzcv[3];
  assign flag_z = nzcv[2];
  assign flag_c = nzcv[1];
  assign flag_v = nzcv[0];

  always_comb begin
    unique case (cond)
      COND_EQ: pass = flag_z;
      COND_NE: pass = !flag_z;
      COND_CS: pass = flag_c;
      COND_CC: pass = !flag_c;
      COND_MI: pass = flag_n;
      COND_PL: pass = !flag_n;
      COND_VS: pass = flag_v;
      COND_VC: pass = !flag_v;
      COND_HI: pass = flag_c && !flag_z;
      COND_LS: pass = !flag_c || flag_z;
      COND_GE: pass = (flag_n == flag_v);
      COND_LT: pass = (flag_n != flag_v);
      COND_GT: pass = !flag_z && (flag_n == flag_v);
      COND_LE: pass = flag_z || (flag_n != flag_v);
      default: pass = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// File: src/atbr_resolve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atbr_resolve: branch decode and address arithmetic
// Turns one registered item into taken, target, link write and exception.
// ----------------------------------------------------------------------------
module atbr_resolve
  import atbr_pkg::*;
(
  input  wire atbr_item_t item,
  output atbr_res_t       res
);

  logic [15:0] t16;
  logic [23:0] imm24;
  logic [31:0] arm_off;
  logic [31:0] blx_off;
  logic [31:0] bcond_off;
  logic [31:0] b_off;
  logic [31:0] bl_hi_off;
  logic [31:0] bl_lo_off;
  logic [31:0] arm_target;
  logic [31:0] blx_target;
  logic [31:0] bcond_target;
  logic [31:0] b_target;
  logic [31:0] bl_lo_link;
  logic [31:0] bl_hi_addr;
  logic [31:0] arm_link;
  logic [31:0] thumb_link;
  logic        cond_ok;
  logic        blx_form;

  assign t16   = item.instr[15:0];
  assign imm24 = item.instr[23:0];

  // The BLX immediate H bit lands on address bit 1 of the word offset.
  assign arm_off   = {{6{imm24[23]}}, imm24, 2'b00};
  assign blx_off   = {{6{imm24[23]}}, imm24, item.instr[24], 1'b0};
  assign bcond_off = {{23{t16[7]}}, t16[7:0], 1'b0};
  assign b_off     = {{20{t16[10]}}, t16[10:0], 1'b0};
  assign bl_lo_off = {{9{t16[10]}}, t16[10:0], 12'h000};
  assign bl_hi_off = {20'h00000, t16[10:0], 1'b0};

  assign arm_target   = item.pc_read + arm_off;
  assign blx_target   = (item.pc_read + blx_off) | 32'h0000_0001;
  assign bcond_target = (item.pc_read + bcond_off) | 32'h0000_0001;
  assign b_target     = (item.pc_read + b_off) | 32'h0000_0001;
  assign bl_lo_link   = item.pc_read + bl_lo_off;
  assign bl_hi_addr   = item.link_in + bl_hi_off;
  assign arm_link     = item.pc_read - 32'd4;
  assign thumb_link   = (item.pc_read - 32'd2) | 32'h0000_0001;

  // Bit 12 clear in the second half selects the switch to ARM state.
  assign blx_form = !t16[12];

  atbr_cond u_cond (
    .cond (t16[11:8]),
    .nzcv (item.nzcv),
    .pass (cond_ok)
  );

  always_comb begin
    res.taken      = 1'b0;
    res.target     = 32'h0000_0000;
    res.link_write = 1'b0;
    res.link_data  = 32'h0000_0000;
    res.fault      = FAULT_NONE;
    unique case (item.req_type)
      KIND_ARM_B: begin
        res.taken  = 1'b1;
        res.target = arm_target;
        if (item.instr[24]) begin
          res.link_write = 1'b1;
          res.link_data  = arm_link;
        end
      end
      KIND_ARM_BX: begin
        res.taken  = 1'b1;
        res.target = item.reg_operand;
        if (item.instr[5]) begin
          res.link_write = 1'b1;
          res.link_data  = arm_link;
        end
      end
      KIND_ARM_BLX_IMM: begin
        res.taken      = 1'b1;
        res.target     = blx_target;
        res.link_write = 1'b1;
        res.link_data  = arm_link;
      end
      KIND_THUMB_BCOND: begin
        if (t16[11:8] == COND_AL) begin
          res.fault = FAULT_UNDEF;
        end else if (t16[11:8] == COND_NV) begin
          res.fault = FAULT_SVC;
        end else if (cond_ok) begin
          res.taken  = 1'b1;
          res.target = bcond_target;
        end
      end
      KIND_THUMB_B: begin
        res.taken  = 1'b1;
        res.target = b_target;
      end
      KIND_THUMB_BL_LO: begin
        res.link_write = 1'b1;
        res.link_data  = bl_lo_link;
      end
      KIND_THUMB_BL_HI: begin
        // An odd offset on the ARM-state form is not a valid encoding.
        if (blx_form && t16[0]) begin
          res.fault = FAULT_UNDEF;
        end else begin
          res.taken      = 1'b1;
          res.target     = blx_form ? (bl_hi_addr & 32'hFFFF_FFFC)
                                    : (bl_hi_addr | 32'h0000_0001);
          res.link_write = 1'b1;
          res.link_data  = thumb_link;
        end
      end
      KIND_THUMB_BX: begin
        res.taken  = 1'b1;
        res.target = item.reg_operand;
        if (t16[7]) begin
          res.link_write = 1'b1;
          res.link_data  = thumb_link;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/arm_thumb_branch_resolve_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arm_thumb_branch_resolve_top: ARM/Thumb branch resolution unit
// Registers each item, resolves it in one pass of logic and holds the
// result in an output register.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  req_type instr pc_read reg_operand
//                                          link_in nzcv
//   out_     output     out_valid/out_stall taken target link_write link_data
//                                          fault
//
// One item per cycle while out_stall is low; each result passes through
// the input register and then the result register.
// Reset clears both valid bits only; payload registers are not reset.
// A stall on the output holds the result register, and the input register
// keeps accepting until it is also occupied, then in_stall rises.
// ----------------------------------------------------------------------------
module arm_thumb_branch_resolve_top
  import atbr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [31:0] in_instr,
  input  wire logic [31:0] in_pc_read,
  input  wire logic [31:0] in_reg_operand,
  input  wire logic [31:0] in_link_in,
  input  wire logic [3:0]  in_nzcv,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_taken,
  output logic [31:0]      out_target,
  output logic             out_link_write,
  output logic [31:0]      out_link_data,
  output logic [1:0]       out_fault
);

  atbr_item_t item_r;
  atbr_item_t item_nxt;
  logic       item_valid_r;
  logic       item_valid_nxt;
  atbr_res_t  res_r;
  atbr_res_t  res_nxt;
  logic       res_valid_r;
  logic       res_valid_nxt;
  logic       res_load;
  logic       item_load;

  // The result register frees up when it is empty or its item leaves now.
  assign res_load  = !res_valid_r || !out_stall;
  assign item_load = !item_valid_r || res_load;
  assign in_stall  = !item_load;

  always_comb begin
    item_nxt.req_type    = atbr_kind_t'(in_req_type);
    item_nxt.instr       = in_instr;
    item_nxt.pc_read     = in_pc_read;
    item_nxt.reg_operand = in_reg_operand;
    item_nxt.link_in     = in_link_in;
    item_nxt.nzcv        = in_nzcv;
  end

  assign item_valid_nxt = item_load ? in_valid : item_valid_r;
  assign res_valid_nxt  = res_load ? item_valid_r : res_valid_r;

  atbr_resolve u_resolve (
    .item (item_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load && in_valid) begin
      item_r <= item_nxt;
    end
    if (res_load && item_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = res_valid_r;
  assign out_taken      = res_r.taken;
  assign out_target     = res_r.target;
  assign out_link_write = res_r.link_write;
  assign out_link_data  = res_r.link_data;
  assign out_fault      = res_r.fault;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_valid_r && res_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_not_taken_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_taken) |-> (out_target == 32'h0000_0000))
    else $error("target nonzero on a branch not taken");

  a_no_link_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_link_write) |-> (out_link_data == 32'h0000_0000))
    else $error("link data nonzero without a link write");

  a_fault_blocks_branch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fault != FAULT_NONE)) |-> (!out_taken && !out_link_write))
    else $error("exception reported together with a branch or link write");
`endif

endmodule
`default_nettype wire
